// ===== src/bzf_pkg.sv =====
`timescale 1ns / 1ps

package bzf_pkg;

    localparam int COORD_W = 32;
    localparam int TOL_W   = 30;
    localparam int IDX_W   = 1;

    localparam logic [TOL_W-1:0] TOL_RESET    = 30'd65536;
    localparam logic [IDX_W-1:0] REG_FLAT_TOL = 1'b0;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W:0]          diff_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [TOL_W-1:0]          tol_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } pt_t;

    typedef struct packed {
        pt_t p3;
        pt_t p2;
        pt_t p1;
        pt_t p0;
    } span_t;

    typedef struct packed {
        pt_t right_c2;
        pt_t right_c1;
        pt_t split;
        pt_t left_c2;
        pt_t left_c1;
    } halves_t;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } pipe_ctl_t;

    function automatic coord_t avg(input coord_t a, input coord_t b);
        logic [COORD_W:0] sum;
        begin
            sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
            avg = sum[COORD_W:1];
        end
    endfunction

    function automatic pt_t mid(input pt_t a, input pt_t b);
        pt_t r;
        begin
            r.x = avg(a.x, b.x);
            r.y = avg(a.y, b.y);
            mid = r;
        end
    endfunction

    function automatic diff_t sub(input coord_t a, input coord_t b);
        sub = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    function automatic mag_t mag(input diff_t d);
        diff_t n;
        begin
            n = d[COORD_W] ? (~d + 1'b1) : d;
            mag = n[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== src/bzf_cfg.sv =====
`timescale 1ns / 1ps

module bzf_cfg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output bzf_pkg::tol_t         flat_tolerance
);

    bzf_pkg::tol_t tol_reg;
    logic [bzf_pkg::IDX_W-1:0] index;
    logic write_hit;

    assign pready    = 1'b1;
    assign index     = paddr[2:2];
    assign write_hit = psel && penable && pwrite && pready && (index == bzf_pkg::REG_FLAT_TOL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= bzf_pkg::TOL_RESET;
        end
        else if (write_hit)
        begin
            tol_reg <= pwdata[bzf_pkg::TOL_W-1:0];
        end
    end

    always_comb
    begin
        unique case (index)
            bzf_pkg::REG_FLAT_TOL: prdata = {{(32 - bzf_pkg::TOL_W){1'b0}}, tol_reg};
            default:               prdata = 32'd0;
        endcase
    end

    assign flat_tolerance = tol_reg;

endmodule

// ===== src/bzf_split.sv =====
`timescale 1ns / 1ps

module bzf_split
(
    input  logic               clk,
    input  bzf_pkg::pipe_ctl_t ctl,
    input  bzf_pkg::span_t     span,
    output bzf_pkg::halves_t   halves
);

    bzf_pkg::pt_t m01_reg;
    bzf_pkg::pt_t m12_reg;
    bzf_pkg::pt_t m23_reg;
    bzf_pkg::pt_t lc1_reg;
    bzf_pkg::pt_t c_reg;
    bzf_pkg::pt_t r_reg;
    bzf_pkg::pt_t rc2_reg;
    bzf_pkg::halves_t out_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            m01_reg <= bzf_pkg::mid(span.p0, span.p1);
            m12_reg <= bzf_pkg::mid(span.p1, span.p2);
            m23_reg <= bzf_pkg::mid(span.p2, span.p3);
        end
        if (ctl.adv2)
        begin
            lc1_reg <= m01_reg;
            c_reg   <= bzf_pkg::mid(m01_reg, m12_reg);
            r_reg   <= bzf_pkg::mid(m12_reg, m23_reg);
            rc2_reg <= m23_reg;
        end
        if (ctl.adv3)
        begin
            out_reg.left_c1  <= lc1_reg;
            out_reg.left_c2  <= c_reg;
            out_reg.split    <= bzf_pkg::mid(c_reg, r_reg);
            out_reg.right_c1 <= r_reg;
            out_reg.right_c2 <= rc2_reg;
        end
    end

    assign halves = out_reg;

endmodule

// ===== src/bzf_flat.sv =====
`timescale 1ns / 1ps

module bzf_flat
(
    input  logic               clk,
    input  bzf_pkg::pipe_ctl_t ctl,
    input  bzf_pkg::span_t     span,
    input  bzf_pkg::tol_t      flat_tolerance,
    output logic               is_flat
);

    localparam int NSTEP = 6;

    bzf_pkg::diff_t diff_reg [NSTEP];
    bzf_pkg::diff_t cdx_reg;
    bzf_pkg::diff_t cdy_reg;
    bzf_pkg::mag_t  step_reg [NSTEP];
    bzf_pkg::mag_t  dx_reg;
    bzf_pkg::mag_t  dy_reg;
    logic           flat_reg;

    bzf_pkg::mag_t  eps;
    bzf_pkg::mag_t  eps4;
    logic           diag;
    logic           ok1;
    logic           ok4;
    logic           flat_next;

    always_ff @(posedge clk)
    begin
        if (ctl.adv1)
        begin
            diff_reg[0] <= bzf_pkg::sub(span.p1.x, span.p0.x);
            diff_reg[1] <= bzf_pkg::sub(span.p1.y, span.p0.y);
            diff_reg[2] <= bzf_pkg::sub(span.p2.x, span.p1.x);
            diff_reg[3] <= bzf_pkg::sub(span.p2.y, span.p1.y);
            diff_reg[4] <= bzf_pkg::sub(span.p3.x, span.p2.x);
            diff_reg[5] <= bzf_pkg::sub(span.p3.y, span.p2.y);
            cdx_reg     <= bzf_pkg::sub(span.p3.x, span.p0.x);
            cdy_reg     <= bzf_pkg::sub(span.p3.y, span.p0.y);
        end
        if (ctl.adv2)
        begin
            for (int i = 0; i < NSTEP; i++)
            begin
                step_reg[i] <= bzf_pkg::mag(diff_reg[i]);
            end
            dx_reg <= bzf_pkg::mag(cdx_reg);
            dy_reg <= bzf_pkg::mag(cdy_reg);
        end
        if (ctl.adv3)
        begin
            flat_reg <= flat_next;
        end
    end

    // The chord counts as near-diagonal when each axis is less than twice the other.
    always_comb
    begin
        eps  = {2'b00, flat_tolerance};
        eps4 = {flat_tolerance, 2'b00};
        diag = ((dy_reg > dx_reg) && ({1'b0, dy_reg} < {dx_reg, 1'b0}))
            || ((dy_reg <= dx_reg) && ({dy_reg, 1'b0} > {1'b0, dx_reg}));
        ok1  = 1'b1;
        ok4  = 1'b1;
        for (int i = 0; i < NSTEP; i++)
        begin
            if (step_reg[i] > eps)
            begin
                ok1 = 1'b0;
            end
            if (step_reg[i] > eps4)
            begin
                ok4 = 1'b0;
            end
        end
        flat_next = diag ? ok4 : ok1;
    end

    assign is_flat = flat_reg;

endmodule

// ===== src/cubic_bezier_split_flatness_core.sv =====
`timescale 1ns / 1ps

// Splits one cubic Bezier span (four 16.16 signed control points) at its
// midpoint and flags whether the span is flat enough to stop subdividing.
// The block takes one span every clock cycle while the output is not
// stalled and passes it through a three-stage pipeline whose last stage is
// the output register; a stalled output holds the pipeline
// without loss. The left half is p0, left_c1, left_c2, split and the right
// half is split, right_c1, right_c2, p3, so the endpoints are not returned.
// The flatness tolerance register sits at byte address 0 of the APB port and
// should be written only while no span is in flight.

module cubic_bezier_split_flatness_core
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    input  logic         s_tvalid,
    output logic         s_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  logic [255:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // left_c1_x, left_c1_y, left_c2_x, left_c2_y, split_x, split_y,
    // right_c1_x, right_c1_y, right_c2_x, right_c2_y
    output logic [319:0] m_tdata,
    // is_flat
    output logic [0:0]   m_tuser
);

    bzf_pkg::pipe_ctl_t ctl;
    bzf_pkg::span_t     span;
    bzf_pkg::halves_t   halves;
    bzf_pkg::tol_t      flat_tolerance;
    logic               is_flat;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;

    always_comb
    begin
        ctl.adv3 = !v3_reg || m_tready;
        ctl.adv2 = !v2_reg || ctl.adv3;
        ctl.adv1 = !v1_reg || ctl.adv2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctl.adv1)
            begin
                v1_reg <= s_tvalid;
            end
            if (ctl.adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctl.adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign span     = s_tdata;
    assign s_tready = ctl.adv1;
    assign m_tvalid = v3_reg;
    assign m_tdata  = halves;
    assign m_tuser  = is_flat;

    bzf_cfg u_cfg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .flat_tolerance (flat_tolerance)
    );

    bzf_split u_split
    (
        .clk    (clk),
        .ctl    (ctl),
        .span   (span),
        .halves (halves)
    );

    bzf_flat u_flat
    (
        .clk            (clk),
        .ctl            (ctl),
        .span           (span),
        .flat_tolerance (flat_tolerance),
        .is_flat        (is_flat)
    );

    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while the output stage is empty");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && v2_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("request accepted into a full, stalled pipeline");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted request did not reach the output in three cycles");

endmodule
